@@ rtl/msct_pkg.sv @@
// shared types, constants and register map of the motor speed calibration tracer
package msct_pkg;

  // default table depth, one entry per motor code
  localparam int unsigned CODE_COUNT_DEF = 256;

  // shared divider widths
  localparam int unsigned DVD_W = 64;
  localparam int unsigned DSR_W = 17;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  // stream widths
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 240;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam logic [ADDR_W-1:0] REG_DIST_PER_PULSE = 4'd0;
  localparam logic [ADDR_W-1:0] REG_SPEED_LOW      = 4'd4;
  localparam logic [ADDR_W-1:0] REG_SPEED_HIGH     = 4'd8;

  localparam logic [15:0] DIST_PER_PULSE_RST = 16'd256;
  localparam logic [23:0] SPEED_LOW_RST      = 24'd6400;
  localparam logic [23:0] SPEED_HIGH_RST     = 24'd23040;

  // speed scale from ms to s
  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [1:0] {
    MODE_PULSE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_FIT   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ZERO_PERIOD = 3'd1;
  localparam logic [2:0] ST_NO_LOW      = 3'd2;
  localparam logic [2:0] ST_NO_HIGH     = 3'd3;
  localparam logic [2:0] ST_SAME_CODE   = 3'd4;

  localparam logic REPORT_TICK = 1'b0;
  localparam logic REPORT_FIT  = 1'b1;

  // one table entry: sample count and running average
  typedef struct packed {
    logic [15:0] n;
    logic [31:0] avg;
  } tab_entry_t;

endpackage

@@ rtl/msct_div.sv @@
// shared restoring divider, one quotient bit per cycle
module msct_div
  import msct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] q;
  logic [DSR_W-1:0] r;
  logic [DSR_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   diff;
  logic             ge;
  logic [DSR_W-1:0] r_next;

  // trial subtraction
  always_comb begin
    shifted = {r, q[DVD_W-1]};
    diff    = shifted - {1'b0, d};
    ge      = shifted >= {1'b0, d};
    r_next  = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      d   <= divisor;
      cnt <= CNT_W'(DVD_W);
    end else if (run) begin
      q   <= {q[DVD_W-2:0], ge};
      r   <= r_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = q;

endmodule

@@ rtl/msct_table.sv @@
// per-code average and sample count memory, registered read
module msct_table
  import msct_pkg::*;
#(
  parameter int unsigned DEPTH = CODE_COUNT_DEF,
  parameter int unsigned AW    = $clog2(CODE_COUNT_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tab_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output tab_entry_t    rdata
);

  tab_entry_t mem [DEPTH];

  // one write and one read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/motor_speed_calibration_tracer.sv @@
// top level: stream ports, register file, sequencer and result register
// After reset the block clears every entry of its code table, one entry a cycle, with
// s_tready low; register writes are taken meanwhile. A pulse event is taken in IDLE.
// A tick runs a 64-step division for the speed if the time span is nonzero and one for
// the running average if the code is in the table, both on the single shared
// one-bit-per-cycle divider. A fit request scans the table one entry a cycle, then runs
// one 64-step division for the slope if both crossing codes are found and differ.
// A finished result waits in the output register while the next item is taken.
module motor_speed_calibration_tracer
  import msct_pkg::*;
#(
  parameter int unsigned CODE_COUNT = CODE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // pulse_level [0], time_span [16:1], motor_code [24:17], zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // mode [1:0]
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // pulse_total [31:0], period_distance [71:32], measured_speed [103:72],
  // elapsed_ms [135:104], slope [183:136], intercept [231:184], status [234:232]
  output logic [M_DATA_W-1:0] m_tdata,
  // report_kind [0]
  output logic                m_tuser,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CW = $clog2(CODE_COUNT);
  localparam int unsigned PW = 35 + CW;

  typedef enum logic [13:0] {
    CLEAR   = 14'b00000000000001,
    IDLE    = 14'b00000000000010,
    T_DIST  = 14'b00000000000100,
    T_SCALE = 14'b00000000001000,
    T_SDIV  = 14'b00000000010000,
    T_AVG   = 14'b00000000100000,
    T_AST   = 14'b00000001000000,
    T_ADIV  = 14'b00000010000000,
    F_SCAN  = 14'b00000100000000,
    F_CHK   = 14'b00001000000000,
    F_DIV   = 14'b00010000000000,
    F_PROD  = 14'b00100000000000,
    F_ICPT  = 14'b01000000000000,
    DONE    = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] dist_per_pulse;
  logic [23:0] speed_low;
  logic [23:0] speed_high;

  // counters
  logic [31:0] pulse_count;
  logic [31:0] prev_count;
  logic [31:0] elapsed;

  // item registers
  logic [31:0] delta;
  logic [15:0] span;
  logic [7:0]  code;
  logic [47:0] period_dist;
  logic [31:0] speed;
  logic [48:0] acc;
  logic [2:0]  status;
  logic        kind;
  logic signed [33:0]   slope;
  logic signed [PW-1:0] prod;
  logic signed [47:0]   icept;

  // scan registers
  logic [CW:0]   sc;
  logic [31:0]   prev_avg;
  logic          lo_found;
  logic          hi_found;
  logic [CW-1:0] c_lo;
  logic [CW-1:0] c_hi;
  logic          neg;

  // divider and table ports
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic             tab_we;
  logic [CW-1:0]    tab_waddr;
  tab_entry_t       tab_wdata;
  logic [CW-1:0]    tab_raddr;
  tab_entry_t       tab_rdata;

  // combinational helpers
  logic                 accept;
  mode_t                in_mode;
  logic                 code_ok;
  logic [CW-1:0]        code_idx;
  logic [CW-1:0]        scan_idx;
  logic signed [24:0]   dt;
  logic [23:0]          dt_mag;
  logic signed [CW:0]   dc;
  logic [CW-1:0]        dc_mag;
  logic signed [33:0]   quot_s;
  logic signed [PW-1:0] prod_adj;
  logic signed [PW-1:0] prod_sh;
  logic                 out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == IDLE);
  assign in_mode  = mode_t'(s_tuser);
  assign code_ok  = (32'(code) < 32'(CODE_COUNT));
  assign code_idx = CW'(code);
  assign scan_idx = CW'(sc - 1'b1);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    dt      = $signed({1'b0, speed_low}) - $signed({1'b0, speed_high});
    dt_mag  = dt[24] ? 24'(-dt) : dt[23:0];
    dc      = $signed({1'b0, c_lo}) - $signed({1'b0, c_hi});
    dc_mag  = dc[CW] ? CW'(-dc) : dc[CW-1:0];
    quot_s  = 34'(div_quot);
    prod_adj = prod + (prod[PW-1] ? $signed(PW'(255)) : $signed(PW'(0)));
    prod_sh  = prod_adj >>> 8;
  end

  // register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_pulse <= DIST_PER_PULSE_RST;
      speed_low      <= SPEED_LOW_RST;
      speed_high     <= SPEED_HIGH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_DIST_PER_PULSE: dist_per_pulse <= pwdata[15:0];
        REG_SPEED_LOW:      speed_low      <= pwdata[23:0];
        REG_SPEED_HIGH:     speed_high     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_DIST_PER_PULSE: prdata = {16'b0, dist_per_pulse};
      REG_SPEED_LOW:      prdata = {8'b0, speed_low};
      REG_SPEED_HIGH:     prdata = {8'b0, speed_high};
      default:            prdata = '0;
    endcase
  end

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      T_SCALE: begin
        div_start    = (span != 16'd0);
        div_dividend = DVD_W'(period_dist) * DVD_W'(MS_PER_S);
        div_divisor  = DSR_W'(span);
      end
      T_AST: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(acc);
        div_divisor  = DSR_W'(tab_rdata.n) + DSR_W'(1);
      end
      F_CHK: begin
        div_start    = lo_found && hi_found && (c_lo != c_hi);
        div_dividend = DVD_W'({dt_mag, 8'b0});
        div_divisor  = DSR_W'(dc_mag);
      end
      default: ;
    endcase
  end

  // table port control
  always_comb begin
    tab_raddr = (state == F_SCAN) ? CW'(sc) : code_idx;
    tab_we    = 1'b0;
    tab_waddr = code_idx;
    tab_wdata.n   = (tab_rdata.n == 16'hFFFF) ? tab_rdata.n : tab_rdata.n + 16'd1;
    tab_wdata.avg = div_quot[31:0];
    if (state == CLEAR) begin
      tab_we    = 1'b1;
      tab_waddr = CW'(sc);
      tab_wdata = '0;
    end else if (state == T_ADIV && div_done) begin
      tab_we = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      sc          <= '0;
      pulse_count <= '0;
      prev_count  <= '0;
      elapsed     <= '0;
    end else begin
      unique case (state)
        CLEAR: begin
          sc <= sc + 1'b1;
          if (sc == (CW+1)'(CODE_COUNT - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            unique case (in_mode)
              MODE_PULSE: begin
                if (s_tdata[0]) begin
                  pulse_count <= pulse_count + 32'd1;
                end
              end
              MODE_TICK: begin
                elapsed    <= elapsed + 32'(s_tdata[16:1]);
                prev_count <= pulse_count;
                state      <= T_DIST;
              end
              MODE_FIT: begin
                sc    <= '0;
                state <= F_SCAN;
              end
              default: ;
            endcase
          end
        end
        T_DIST:  state <= T_SCALE;
        T_SCALE: state <= (span == 16'd0) ? DONE : T_SDIV;
        T_SDIV: begin
          if (div_done) begin
            state <= code_ok ? T_AVG : DONE;
          end
        end
        T_AVG: state <= T_AST;
        T_AST: state <= T_ADIV;
        T_ADIV: begin
          if (div_done) begin
            state <= DONE;
          end
        end
        F_SCAN: begin
          sc <= sc + 1'b1;
          if (sc == (CW+1)'(CODE_COUNT)) begin
            state <= F_CHK;
          end
        end
        F_CHK:  state <= div_start ? F_DIV : DONE;
        F_DIV: begin
          if (div_done) begin
            state <= F_PROD;
          end
        end
        F_PROD: state <= F_ICPT;
        F_ICPT: state <= DONE;
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      IDLE: begin
        delta  <= pulse_count - prev_count;
        span   <= s_tdata[16:1];
        code   <= s_tdata[24:17];
        period_dist <= '0;
        speed  <= '0;
        slope  <= '0;
        prod   <= '0;
        icept  <= '0;
        status <= ST_OK;
        kind   <= (in_mode == MODE_FIT) ? REPORT_FIT : REPORT_TICK;
        lo_found <= 1'b0;
        hi_found <= 1'b0;
      end
      T_DIST: period_dist <= 48'(dist_per_pulse) * 48'(delta);
      T_SCALE: begin
        if (span == 16'd0) begin
          status <= ST_ZERO_PERIOD;
        end
      end
      T_SDIV: begin
        if (div_done) begin
          speed <= (div_quot[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
        end
      end
      T_AVG: acc <= 49'(tab_rdata.avg) * 49'(tab_rdata.n) + 49'(speed);
      F_SCAN: begin
        // data from address sc-1 is on the read port
        if (sc >= (CW+1)'(1)) begin
          prev_avg <= tab_rdata.avg;
        end
        if (sc >= (CW+1)'(2)) begin
          if (prev_avg <= 32'(speed_low) && tab_rdata.avg > 32'(speed_low)) begin
            lo_found <= 1'b1;
            c_lo     <= scan_idx;
          end
          if (prev_avg <= 32'(speed_high) && tab_rdata.avg > 32'(speed_high)) begin
            hi_found <= 1'b1;
            c_hi     <= scan_idx;
          end
        end
      end
      F_CHK: begin
        neg <= dt[24] ^ dc[CW];
        priority if (!lo_found) begin
          status <= ST_NO_LOW;
        end else if (!hi_found) begin
          status <= ST_NO_HIGH;
        end else if (c_lo == c_hi) begin
          status <= ST_SAME_CODE;
        end
      end
      F_DIV: begin
        if (div_done) begin
          slope <= neg ? -quot_s : quot_s;
        end
      end
      F_PROD: prod <= slope * $signed({1'b0, c_hi});
      F_ICPT: icept <= $signed({24'b0, speed_high}) - 48'(prod_sh);
      default: ;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == DONE && out_free) begin
      m_tuser <= kind;
      m_tdata <= {5'b0, status, icept, 48'(slope), elapsed, speed,
                  (period_dist[47:40] != 8'd0) ? 40'hFF_FFFF_FFFF : period_dist[39:0],
                  pulse_count};
    end
  end

  msct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  msct_table #(
    .DEPTH (CODE_COUNT),
    .AW    (CW)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

endmodule

@@ rtl/msct_checker.sv @@
// port-level checks of the tracer, bound to the top level
module msct_checker
  import msct_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [1:0]          s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // ticks and fits keep the block busy the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == MODE_TICK || s_tuser == MODE_FIT) |=> !s_tready)
    else $error("input taken during a multi-cycle transfer");

  // tick reports carry no fit
  a_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REPORT_TICK |-> m_tdata[231:136] == '0)
    else $error("tick report with fit fields");

  // fit reports carry no distance or speed
  a_fit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REPORT_FIT |-> m_tdata[103:32] == '0)
    else $error("fit report with speed fields");

endmodule

bind motor_speed_calibration_tracer msct_checker u_msct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
